[hw/rtl/ddt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ddt_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    REG_LOAD    = 3'd0,
    REG_VALUE   = 3'd1,
    REG_CONTROL = 3'd2,
    REG_INTCLR  = 3'd3,
    REG_RIS     = 3'd4,
    REG_MIS     = 3'd5,
    REG_BGLOAD  = 3'd6
  } reg_idx_t;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [1:0] PRE_DIV16  = 2'd1;
  localparam logic [1:0] PRE_DIV256 = 2'd2;

  localparam int CTL_ONESHOT  = 0;
  localparam int CTL_WIDE     = 1;
  localparam int CTL_IE       = 5;
  localparam int CTL_PERIODIC = 6;
  localparam int CTL_ENABLE   = 7;

  localparam logic [7:0]  CTL_RESET   = 8'h20;
  localparam logic [31:0] LOAD_RESET  = 32'hFFFF_FFFF;
  localparam logic [11:0] ID_BASE     = 12'hFE0;
  localparam logic [11:0] TIMER_LIMIT = 12'h040;
  localparam logic [31:0] KEEP_BYTE   = 32'hFFFF_FF00;
  localparam logic [31:0] KEEP_HALF   = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [1:0]  access_size;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_offset;
    logic        irq_first;
    logic        irq_second;
  } rsp_t;

  typedef struct packed {
    logic        tick;
    logic        wr_load;
    logic        wr_ctl;
    logic        start;
    logic        clr;
    logic [31:0] wdata;
    logic [31:0] keep;
  } tmr_cmd_t;

  typedef struct packed {
    logic [31:0] load;
    logic [31:0] count;
    logic [7:0]  ctl;
    logic        raw;
    logic        irq_next;
  } tmr_stat_t;

  function automatic logic [31:0] reload_of(input logic [7:0] ctl, input logic [31:0] load);
    logic [31:0] v;
    v = (ctl[CTL_ONESHOT] || ctl[CTL_PERIODIC]) ? load : LOAD_RESET;
    if (!ctl[CTL_WIDE]) begin
      v = {16'h0000, v[15:0]};
    end
    return v;
  endfunction

  function automatic logic [7:0] pre_limit(input logic [1:0] sel);
    logic [7:0] l;
    case (sel)
      PRE_DIV16:  l = 8'd15;
      PRE_DIV256: l = 8'd255;
      default:    l = 8'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h04;
      3'd1:    b = 8'h18;
      3'd2:    b = 8'h14;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'hF0;
      3'd6:    b = 8'h05;
      3'd7:    b = 8'hB1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ddt_timer.sv]
`timescale 1ns / 1ps
`default_nettype none

module ddt_timer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  ddt_pkg::tmr_cmd_t   cmd,
  output ddt_pkg::tmr_stat_t  stat
);
  import ddt_pkg::*;

  logic [31:0] load, load_next;
  logic [31:0] count, count_next;
  logic [7:0]  ctl, ctl_next;
  logic        raw, raw_next;
  logic [7:0]  pre, pre_next;

  always_comb begin
    load_next  = cmd.wr_load ? ((load & cmd.keep) | (cmd.wdata & ~cmd.keep)) : load;
    ctl_next   = cmd.wr_ctl ? cmd.wdata[7:0] : ctl;
    raw_next   = cmd.clr ? 1'b0 : raw;
    count_next = count;
    pre_next   = pre;
    // a load or control write restarts a running timer
    if (cmd.start && ctl_next[CTL_ENABLE]) begin
      count_next = reload_of(ctl_next, load_next);
      pre_next   = 8'd0;
    end
    if (cmd.tick && ctl[CTL_ENABLE]) begin
      if (pre < pre_limit(ctl[3:2])) begin
        pre_next = pre + 8'd1;
      end else begin
        pre_next = 8'd0;
        if (count > 32'd1) begin
          count_next = count - 32'd1;
        end else begin
          raw_next = 1'b1;
          if (ctl[CTL_ONESHOT]) begin
            count_next           = 32'd0;
            ctl_next[CTL_ENABLE] = 1'b0;
          end else begin
            count_next = reload_of(ctl, load);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load  <= LOAD_RESET;
      count <= 32'd0;
      ctl   <= CTL_RESET;
      raw   <= 1'b0;
      pre   <= 8'd0;
    end else if (en) begin
      load  <= load_next;
      count <= count_next;
      ctl   <= ctl_next;
      raw   <= raw_next;
      pre   <= pre_next;
    end
  end

  always_comb begin
    stat.load     = load;
    stat.count    = count;
    stat.ctl      = ctl;
    stat.raw      = raw;
    stat.irq_next = raw_next & ctl_next[CTL_ENABLE] & ctl_next[CTL_IE];
  end

endmodule

`default_nettype wire

[hw/rtl/ddt_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module ddt_decode #(
  parameter int NUM_TIMERS = 2
) (
  input  ddt_pkg::req_t             req,
  input  ddt_pkg::tmr_stat_t [1:0]  stat,
  output ddt_pkg::tmr_cmd_t  [1:0]  cmd,
  output logic [31:0]               read_data,
  output logic                      bad_offset
);
  import ddt_pkg::*;

  logic        is_rd, is_wr, is_id, in_range, tsel;
  logic [31:0] keep, v;
  logic        rd_bad, wr_bad;
  reg_idx_t    ridx;
  tmr_stat_t   s;

  assign is_rd    = req.req_type == REQ_READ;
  assign is_wr    = req.req_type == REQ_WRITE;
  assign is_id    = req.offset >= ID_BASE;
  assign tsel     = req.offset[5];
  assign in_range = (req.offset < TIMER_LIMIT) && (int'(tsel) < NUM_TIMERS);
  assign ridx     = reg_idx_t'(req.offset[4:2]);
  assign s        = stat[tsel];

  always_comb begin
    case (req.access_size)
      SIZE_BYTE: keep = KEEP_BYTE;
      SIZE_HALF: keep = KEEP_HALF;
      default:   keep = 32'd0;
    endcase
  end

  always_comb begin
    v      = 32'd0;
    rd_bad = 1'b0;
    if (is_id) begin
      v = {24'd0, id_byte(req.offset[4:2])};
    end else begin
      case (ridx)
        REG_LOAD, REG_BGLOAD: v = s.load;
        REG_VALUE:            v = s.ctl[CTL_ENABLE] ? s.count : 32'd0;
        REG_CONTROL:          v = {24'd0, s.ctl};
        REG_RIS:              v = {31'd0, s.raw};
        REG_MIS:              v = {31'd0, s.raw & s.ctl[CTL_IE]};
        default:              rd_bad = 1'b1;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_LOAD, REG_VALUE, REG_CONTROL, REG_INTCLR, REG_BGLOAD: wr_bad = 1'b0;
      default:                                                   wr_bad = 1'b1;
    endcase
  end

  always_comb begin
    read_data  = 32'd0;
    bad_offset = 1'b0;
    if (is_rd || is_wr) begin
      if (!is_id && !in_range) begin
        bad_offset = 1'b1;
      end else if (is_rd) begin
        bad_offset = rd_bad;
        read_data  = rd_bad ? 32'd0 : (v & ~keep);
      end else if (!is_id) begin
        bad_offset = wr_bad;
      end
    end
  end

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      logic hit;
      hit = is_wr && !is_id && in_range && (tsel == t[0]);
      cmd[t].tick    = req.req_type == REQ_TICK;
      cmd[t].wr_load = hit && (ridx == REG_LOAD || ridx == REG_BGLOAD);
      cmd[t].wr_ctl  = hit && (ridx == REG_CONTROL);
      cmd[t].start   = hit && (ridx == REG_LOAD || ridx == REG_CONTROL);
      cmd[t].clr     = hit && (ridx == REG_INTCLR);
      cmd[t].wdata   = req.write_data;
      cmd[t].keep    = keep;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dual_down_counter_timer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Dual down-counting timer with a bus-style register map.
// Request channel (req_valid/req_ready/req): each request is a register read,
// a masked byte/halfword/word write, or one reference clock tick. Offsets
// 0x00-0x1F address timer 0, 0x20-0x3F timer 1, 0xFE0-0xFFC the ID bytes.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
// request, in order, carrying read data, the bad offset flag and both
// interrupt lines as they stand after the request has taken effect.
// An accepted request sits in the input register, and its response is then
// captured in the response register. Throughput is one request per cycle
// while the receiver does not stall; the decode sits combinationally between
// the two registers, and both timers update when the response is captured.
// Reset (rst, synchronous): both stages empty, each timer disabled with
// load all ones, count zero, interrupt enable set, raw flag clear.
// When the receiver stalls, the response holds and one more request is
// taken into the input register; req_ready then drops until rsp_ready
// returns.
module dual_down_counter_timer #(
  parameter int NUM_TIMERS = 2
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  ddt_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output ddt_pkg::rsp_t  rsp
);
  import ddt_pkg::*;

  req_t                req_q;
  logic                req_q_valid;
  rsp_t                rsp_q;
  logic                advance;
  tmr_stat_t [1:0]     stat;
  tmr_cmd_t  [1:0]     cmd;
  logic [31:0]         rdata;
  logic                bad;

  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req;
    end
  end

  ddt_decode #(.NUM_TIMERS(NUM_TIMERS)) u_decode (
    .req        (req_q),
    .stat       (stat),
    .cmd        (cmd),
    .read_data  (rdata),
    .bad_offset (bad)
  );

  for (genvar t = 0; t < 2; t++) begin : g_tmr
    if (t < NUM_TIMERS) begin : g_on
      ddt_timer u_timer (
        .clk  (clk),
        .rst  (rst),
        .en   (advance),
        .cmd  (cmd[t]),
        .stat (stat[t])
      );
    end else begin : g_off
      assign stat[t] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q.read_data  <= rdata;
      rsp_q.bad_offset <= bad;
      rsp_q.irq_first  <= stat[0].irq_next;
      rsp_q.irq_second <= stat[1].irq_next;
    end
  end

  assign rsp = rsp_q;

endmodule

`default_nettype wire

[hw/rtl/ddt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ddt_checker (
  input wire            clk,
  input wire            rst,
  input wire            req_valid,
  input wire            req_ready,
  input wire            rsp_valid,
  input wire            rsp_ready,
  input ddt_pkg::rsp_t  rsp
);
  import ddt_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_offset |-> rsp.read_data == 32'd0)
    else $error("bad offset with nonzero read data");

  // one request accepted with the response side open moves through in time
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
    else $error("response missing after request");

  // both stages full and stalled: no further request taken
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && rsp_valid && !rsp_ready) ##1 !rsp_ready |-> !req_ready)
    else $error("request taken with both stages full");

endmodule

bind dual_down_counter_timer ddt_checker u_ddt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
